// ===== rtl/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types and the P1/P2/P3 register byte packing for the clock
// synthesizer parameter calculator.
// ----------------------------------------------------------------------------
package csp_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_TMUL,
        ST_TCHK,
        ST_DIVA,
        ST_MUL,
        ST_DIVB,
        ST_DIVC,
        ST_DONE
    } state_t;

    // input action codes
    localparam logic ACT_SET  = 1'b0;
    localparam logic ACT_TUNE = 1'b1;

    // VCO window and aim point
    localparam logic [37:0] VCO_LOW  = 38'd600000000;
    localparam logic [37:0] VCO_HIGH = 38'd900000000;
    localparam logic [37:0] VCO_AIM  = 38'd800000000;

    localparam logic [7:0] DIV_FIRST   = 8'd6;
    localparam logic [7:0] DIV_LAST    = 8'd150;
    localparam logic [7:0] DIV_DEFAULT = 8'd10;

    // pack m + q/128 with remainder p2 over denominator den
    function automatic logic [63:0] encode(input logic [31:0] m, input logic [7:0] q,
                                           input logic [19:0] p2, input logic [19:0] den);
        logic [17:0] p1;
        p1 = {m[10:0], 7'b0} + {10'b0, q} - 18'd512;
        return {den[15:8], den[7:0], 6'b0, p1[17:16], p1[15:8], p1[7:0],
                den[19:16], p2[19:16], p2[15:8], p2[7:0]};
    endfunction

endpackage

// ===== rtl/clock_synth_param_calculator_core.sv =====
// ----------------------------------------------------------------------------
// clock_synth_param_calculator_core
// Computes PLL and output divider register bytes for set-carrier and
// tune-offset commands with one shared restoring divider.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  s_       | in        | action, rf_freq_hz, offset_millihz
//  m_       | out       | pll/ms register bytes, written flags, divider, vco
//  cfg_     | in        | ref_freq_hz
//
//  Set: the divider search, the integer division, the multiply, the two
//  fractional divisions and the output register, in that order.
//  Tune: the products and their check, then the same divisions and multiply.
//  The divider is bit-serial and gives one quotient bit a cycle.
//  s_ready is high only in idle; a done word waits for the output register.
//  Reset is synchronous, active low, and clears control and held state.
// ----------------------------------------------------------------------------
module clock_synth_param_calculator_core #(
    parameter int FRAC_DENOM = 1048575
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [27:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [27:0]        s_rf_freq_hz,
    input  logic signed [24:0] s_offset_millihz,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_pll_regs,
    output logic               m_pll_written,
    output logic [63:0]        m_ms_regs,
    output logic               m_ms_written,
    output logic [7:0]         m_chosen_divider,
    output logic [31:0]        m_vco_freq_hz
);

    localparam logic [19:0] FD = 20'(FRAC_DENOM);

    csp_pkg::state_t state_reg, state_next;

    logic [27:0] ref_reg;
    logic        carrier_reg;
    logic [31:0] vco_reg;
    logic [7:0]  div_reg;

    // search
    logic [30:0] clk_reg;
    logic [37:0] v_reg;
    logic [7:0]  cand_reg, best_reg;
    logic [31:0] bestv_reg, mindiff_reg;
    logic        rfnz_reg;

    // tune
    logic signed [24:0] off_reg;
    logic [41:0]        pa_reg;
    logic signed [36:0] pb_reg;
    logic [37:0]        refm_reg;

    // divider
    logic [37:0] rem_reg, dvs_reg;
    logic [57:0] dq_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] a_reg;

    // results under construction
    logic [63:0] pll_reg, ms_reg;
    logic        pllw_reg, msw_reg;

    logic        take, out_load;

    // search step
    logic        in_win, better;
    logic [37:0] dv;
    logic [7:0]  best_sel;
    logic [31:0] bestv_sel;

    always_comb begin
        in_win    = (v_reg >= csp_pkg::VCO_LOW) && (v_reg <= csp_pkg::VCO_HIGH);
        dv        = (v_reg > csp_pkg::VCO_AIM) ? v_reg - csp_pkg::VCO_AIM
                                               : csp_pkg::VCO_AIM - v_reg;
        better    = in_win && (dv[31:0] < mindiff_reg);
        best_sel  = better ? cand_reg : best_reg;
        bestv_sel = better ? v_reg[31:0] : bestv_reg;
    end

    // divider step
    logic [38:0] rsh, rsub;
    logic        ge;
    logic [37:0] rem_step;
    logic [57:0] dq_step;

    always_comb begin
        rsh      = {rem_reg, dq_reg[57]};
        rsub     = rsh - {1'b0, dvs_reg};
        ge       = rsh >= {1'b0, dvs_reg};
        rem_step = ge ? rsub[37:0] : rsh[37:0];
        dq_step  = {dq_reg[56:0], ge};
    end

    logic signed [44:0] target;
    assign target = $signed({3'b0, pa_reg}) + 45'(pb_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            csp_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == csp_pkg::ACT_SET) begin
                        state_next = csp_pkg::ST_SRCH;
                    end else if (carrier_reg && ref_reg != 28'd0) begin
                        state_next = csp_pkg::ST_TMUL;
                    end else begin
                        state_next = csp_pkg::ST_DONE;
                    end
                end
            end
            csp_pkg::ST_SRCH: begin
                if (cand_reg == csp_pkg::DIV_LAST) begin
                    state_next = (ref_reg != 28'd0) ? csp_pkg::ST_DIVA : csp_pkg::ST_DONE;
                end
            end
            csp_pkg::ST_TMUL: state_next = csp_pkg::ST_TCHK;
            csp_pkg::ST_TCHK: begin
                state_next = (target > 45'sd0) ? csp_pkg::ST_DIVA : csp_pkg::ST_DONE;
            end
            csp_pkg::ST_DIVA: if (cnt_reg == 6'd1) state_next = csp_pkg::ST_MUL;
            csp_pkg::ST_MUL:  state_next = csp_pkg::ST_DIVB;
            csp_pkg::ST_DIVB: if (cnt_reg == 6'd1) state_next = csp_pkg::ST_DIVC;
            csp_pkg::ST_DIVC: if (cnt_reg == 6'd1) state_next = csp_pkg::ST_DONE;
            csp_pkg::ST_DONE: if (!m_valid || m_ready) state_next = csp_pkg::ST_IDLE;
            default:          state_next = csp_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready   = (state_reg == csp_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        take      = s_valid && s_ready;
        out_load  = (state_reg == csp_pkg::ST_DONE) && (!m_valid || m_ready);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= csp_pkg::ST_IDLE;
            ref_reg     <= 28'd0;
            carrier_reg <= 1'b0;
            vco_reg     <= 32'd0;
            div_reg     <= 8'd0;
            m_valid     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) ref_reg <= cfg_wdata;
            if (state_reg == csp_pkg::ST_SRCH && cand_reg == csp_pkg::DIV_LAST) begin
                carrier_reg <= rfnz_reg;
                vco_reg     <= bestv_sel;
                div_reg     <= best_sel;
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            csp_pkg::ST_IDLE: begin
                if (take) begin
                    clk_reg     <= 31'(s_rf_freq_hz) * 31'd6;
                    v_reg       <= 38'(s_rf_freq_hz) * 38'd36;
                    bestv_reg   <= s_rf_freq_hz * 32'd60;
                    best_reg    <= csp_pkg::DIV_DEFAULT;
                    cand_reg    <= csp_pkg::DIV_FIRST;
                    mindiff_reg <= 32'hFFFF_FFFF;
                    rfnz_reg    <= (s_rf_freq_hz != 28'd0);
                    off_reg     <= s_offset_millihz;
                    pll_reg     <= 64'd0;
                    pllw_reg    <= 1'b0;
                    ms_reg      <= 64'd0;
                    msw_reg     <= 1'b0;
                end
            end
            csp_pkg::ST_SRCH: begin
                best_reg    <= best_sel;
                bestv_reg   <= bestv_sel;
                if (better) mindiff_reg <= dv[31:0];
                v_reg       <= v_reg + {6'b0, clk_reg, 1'b0};
                cand_reg    <= cand_reg + 8'd2;
                if (cand_reg == csp_pkg::DIV_LAST) begin
                    ms_reg  <= csp_pkg::encode({24'b0, best_sel}, 8'd0, 20'd0, FD);
                    msw_reg <= 1'b1;
                    dvs_reg <= {10'b0, ref_reg};
                    rem_reg <= 38'd0;
                    dq_reg  <= {bestv_sel, 26'b0};
                    cnt_reg <= 6'd32;
                end
            end
            csp_pkg::ST_TMUL: begin
                pa_reg   <= 42'(vco_reg) * 42'd1000;
                pb_reg   <= $signed({29'b0, div_reg}) * (37'(off_reg) * 37'sd6);
                refm_reg <= 38'(ref_reg) * 38'd1000;
            end
            csp_pkg::ST_TCHK: begin
                dvs_reg <= refm_reg;
                rem_reg <= 38'd0;
                dq_reg  <= {target[43:0], 14'b0};
                cnt_reg <= 6'd44;
            end
            csp_pkg::ST_DIVA: begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) a_reg <= dq_step[31:0];
            end
            csp_pkg::ST_MUL: begin
                dq_reg  <= rem_reg * FD;
                rem_reg <= 38'd0;
                cnt_reg <= 6'd58;
            end
            csp_pkg::ST_DIVB: begin
                if (cnt_reg == 6'd1) begin
                    // b is done; start 128*b / den for P1/P2
                    dq_reg  <= {dq_step[19:0], 38'b0};
                    rem_reg <= 38'd0;
                    dvs_reg <= {18'b0, FD};
                    cnt_reg <= 6'd27;
                end else begin
                    rem_reg <= rem_step;
                    dq_reg  <= dq_step;
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            csp_pkg::ST_DIVC: begin
                rem_reg <= rem_step;
                dq_reg  <= dq_step;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    pll_reg  <= csp_pkg::encode(a_reg, {1'b0, dq_step[6:0]},
                                                rem_step[19:0], FD);
                    pllw_reg <= 1'b1;
                end
            end
            csp_pkg::ST_DONE: begin
                if (out_load) begin
                    m_pll_regs       <= pll_reg;
                    m_pll_written    <= pllw_reg;
                    m_ms_regs        <= ms_reg;
                    m_ms_written     <= msw_reg;
                    m_chosen_divider <= div_reg;
                    m_vco_freq_hz    <= vco_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/csp_checker.sv =====
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the clock synthesizer parameter calculator.
// ----------------------------------------------------------------------------
module csp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_pll_regs,
    input logic        m_pll_written,
    input logic [63:0] m_ms_regs,
    input logic        m_ms_written,
    input logic [7:0]  m_chosen_divider
);

    // a held word stays until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pll_regs))
        else $error("result word dropped or changed while stalled");

    // busy right after an accepted word
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted during computation");

    // unwritten fields read zero
    a_pll_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pll_written |-> m_pll_regs == 64'd0)
        else $error("stale PLL bytes");

    a_ms_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ms_written |-> m_ms_regs == 64'd0)
        else $error("stale divider bytes");

    // a set picks an even divider in range
    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ms_written |-> !m_chosen_divider[0] &&
            m_chosen_divider >= 8'd6 && m_chosen_divider <= 8'd150)
        else $error("divider out of range");

endmodule

bind clock_synth_param_calculator_core csp_checker u_csp_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_pll_regs       (m_pll_regs),
    .m_pll_written    (m_pll_written),
    .m_ms_regs        (m_ms_regs),
    .m_ms_written     (m_ms_written),
    .m_chosen_divider (m_chosen_divider)
);
